/* design/nibble_stuff_manchester_frame_encoder_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame encoder
// Shared concurrent assertion forms used by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_STUFF_MANCHESTER_FRAME_ENCODER_CORE_DEFINES_SVH
`define NIBBLE_STUFF_MANCHESTER_FRAME_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSME_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define NSME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/nsme_pkg.sv */
// ----------------------------------------------------------------------------
// nsme_pkg
// Types, constants and line-code functions of the frame encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsme_pkg;

    localparam int unsigned MAX_RESULTS = 7;
    localparam int unsigned CNT_W = 3;

    // Configuration register indexes.
    localparam logic CFG_EVEN_FOOTER = 1'b0;
    localparam logic CFG_ODD_FOOTER  = 1'b1;

    // Line bits that complete an odd frame: two raw ones.
    localparam logic [3:0] PAD_LINE = 4'hA;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] running_sum;
        logic [3:0] pending_bits;
        logic       pending_valid;
    } enc_state_t;

    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] entries;
        logic [CNT_W-1:0]            count;
    } burst_t;

    // Ten line bits of one nibble: data bits LSB first, then a stop one.
    function automatic logic [9:0] nibble_line(input logic [3:0] nib);
        nibble_line = {nib[0], ~nib[0], nib[1], ~nib[1],
                       nib[2], ~nib[2], nib[3], ~nib[3], 2'b10};
    endfunction

    // Twenty line bits of one byte, high nibble first.
    function automatic logic [19:0] byte_line(input logic [7:0] b);
        byte_line = {nibble_line(b[7:4]), nibble_line(b[3:0])};
    endfunction

endpackage

/* design/nsme_encode.sv */
// ----------------------------------------------------------------------------
// nsme_encode
// Turns one registered item and the frame state into a burst of coded bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsme_encode
    import nsme_pkg::*;
(
    input  in_item_t   item,
    input  enc_state_t state_cur,
    input  logic [7:0] even_footer,
    input  logic [7:0] odd_footer,
    output burst_t     burst,
    output enc_state_t state_next
);

    logic [7:0]       sum_new;
    logic [7:0]       check;
    logic [19:0]      code_data;
    logic [19:0]      code_check;
    logic [23:0]      acc;
    logic [2:0]       idx;
    logic [3:0]       pb;
    logic             pv;

    assign sum_new    = state_cur.running_sum + item.data_byte;
    assign check      = 8'd0 - sum_new;
    assign code_data  = byte_line(item.data_byte);
    assign code_check = byte_line(check);

    always_comb begin
        burst = '0;
        idx   = '0;
        pb    = state_cur.pending_bits;
        pv    = state_cur.pending_valid;
        acc   = '0;

        // Payload byte.
        if (pv) begin
            acc = {pb, code_data};
            burst.entries[idx]       = '{coded_byte: acc[23:16], frame_end: 1'b0};
            burst.entries[idx + 3'd1] = '{coded_byte: acc[15:8], frame_end: 1'b0};
            burst.entries[idx + 3'd2] = '{coded_byte: acc[7:0], frame_end: 1'b0};
            idx = idx + 3'd3;
            pb  = '0;
            pv  = 1'b0;
        end else begin
            burst.entries[idx]       = '{coded_byte: code_data[19:12], frame_end: 1'b0};
            burst.entries[idx + 3'd1] = '{coded_byte: code_data[11:4], frame_end: 1'b0};
            idx = idx + 3'd2;
            pb  = code_data[3:0];
            pv  = 1'b1;
        end

        if (item.last_byte) begin
            // Checksum byte.
            if (pv) begin
                acc = {pb, code_check};
                burst.entries[idx]       = '{coded_byte: acc[23:16], frame_end: 1'b0};
                burst.entries[idx + 3'd1] = '{coded_byte: acc[15:8], frame_end: 1'b0};
                burst.entries[idx + 3'd2] = '{coded_byte: acc[7:0], frame_end: 1'b0};
                idx = idx + 3'd3;
                pb  = '0;
                pv  = 1'b0;
            end else begin
                burst.entries[idx]       = '{coded_byte: code_check[19:12], frame_end: 1'b0};
                burst.entries[idx + 3'd1] = '{coded_byte: code_check[11:4], frame_end: 1'b0};
                idx = idx + 3'd2;
                pb  = code_check[3:0];
                pv  = 1'b1;
            end

            // Padding and footer.
            if (pv) begin
                burst.entries[idx]       = '{coded_byte: {pb, PAD_LINE}, frame_end: 1'b0};
                burst.entries[idx + 3'd1] = '{coded_byte: odd_footer, frame_end: 1'b1};
                idx = idx + 3'd2;
            end else begin
                burst.entries[idx] = '{coded_byte: even_footer, frame_end: 1'b1};
                idx = idx + 3'd1;
            end
            pb = '0;
            pv = 1'b0;
        end

        burst.count = idx;
    end

    always_comb begin
        if (item.last_byte) begin
            state_next = '0;
        end else begin
            state_next.running_sum   = sum_new;
            state_next.pending_bits  = pb;
            state_next.pending_valid = pv;
        end
    end

endmodule

/* design/nsme_obuf.sv */
// ----------------------------------------------------------------------------
// nsme_obuf
// Result buffer: holds a burst of coded bytes, sends one per cycle while ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsme_obuf
    import nsme_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  burst_t            burst,
    input  logic              m_ready,
    output logic              m_valid,
    output out_item_t         m_data,
    output logic [CNT_W-1:0]  count
);

    out_item_t [MAX_RESULTS-1:0] entries_reg;
    out_item_t [MAX_RESULTS-1:0] entries_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic                        pop;

    assign m_valid = (cnt_reg != '0);
    assign m_data  = entries_reg[0];
    assign count   = cnt_reg;
    assign pop     = m_valid && m_ready;

    always_comb begin
        entries_next = entries_reg;
        cnt_next     = cnt_reg;
        if (load) begin
            entries_next = burst.entries;
            cnt_next     = burst.count;
        end else if (pop) begin
            // Shift the queue down by one entry.
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                entries_next[i] = entries_reg[i + 1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        entries_reg <= entries_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* design/nibble_stuff_manchester_frame_encoder_core.sv */
// ----------------------------------------------------------------------------
// nibble_stuff_manchester_frame_encoder_core
// Frame line encoder: checksum, nibble stuffing and Manchester coding.
// ----------------------------------------------------------------------------
// Each payload item is one byte with a last flag. The block keeps an 8-bit
// running sum and, after the last byte, appends the two's-complement
// checksum so that the frame sums to zero. Every byte is split into nibbles
// (high first), each nibble goes out as its four bits LSB first plus a stop
// one, and every raw bit is Manchester coded as the bit followed by its
// inverse. Line bits are packed into bytes MSB first. A frame with an odd
// byte count is padded with two raw ones, and a footer byte chosen by the
// parity of the frame's byte count closes it with frame_end set. A payload
// byte produces two or three result items and a last byte six or seven; the
// result port sends one item per cycle while m_ready is high, so the
// sustained rate is set by that port. The input register takes the next
// item while the result buffer is still draining, and a new burst is loaded
// in the same cycle as the final item of the previous one leaves, so the
// result port streams without gaps. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nibble_stuff_manchester_frame_encoder_core_defines.svh"

module nibble_stuff_manchester_frame_encoder_core
    import nsme_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);

    // Configuration registers.
    logic [7:0] even_footer_reg;
    logic [7:0] odd_footer_reg;

    // Input register: holds one item until its burst goes into the buffer.
    in_item_t   item_reg;
    logic       item_valid_reg;

    // Frame state, updated when a burst is loaded.
    enc_state_t state_reg;
    enc_state_t state_next;

    burst_t            burst;
    logic              load;
    logic [CNT_W-1:0]  buf_count;

    // The buffer may take a new burst when it is empty or its final item is
    // leaving in this cycle.
    assign load    = item_valid_reg &&
                     ((buf_count == '0) || ((buf_count == 3'd1) && m_ready));
    assign s_ready = !item_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            even_footer_reg <= '0;
            odd_footer_reg  <= '0;
            item_valid_reg  <= 1'b0;
            state_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EVEN_FOOTER: even_footer_reg <= cfg_wdata;
                    CFG_ODD_FOOTER:  odd_footer_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                item_valid_reg <= 1'b1;
            end else if (load) begin
                item_valid_reg <= 1'b0;
            end
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    nsme_encode u_encode (
        .item        (item_reg),
        .state_cur   (state_reg),
        .even_footer (even_footer_reg),
        .odd_footer  (odd_footer_reg),
        .burst       (burst),
        .state_next  (state_next)
    );

    nsme_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .burst   (burst),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .count   (buf_count)
    );

    // The footer is always the final item of its burst.
    `NSME_ASSERT_IMPLY(a_footer_last, aclk, aresetn, m_valid && m_data.frame_end, buf_count == 3'd1)
    // A burst is never loaded over items that are not yet delivered.
    `NSME_ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, load, (buf_count == '0) || m_ready)
    // Closing a frame returns the frame state to zero.
    `NSME_ASSERT_NEXT(a_frame_reset, aclk, aresetn, load && item_reg.last_byte, state_reg == '0)
    // A loaded burst holds two to seven items.
    `NSME_ASSERT_NEXT(a_burst_size, aclk, aresetn, load, buf_count >= 3'd2)

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Frame encoder testbench
// Drives payload items with random gaps and back-pressure, rebuilds the
// expected line-coded bytes of every frame, and checks each result item in
// order against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import nsme_pkg::*;

    // Two raw ones after Manchester coding, used to complete an odd frame.
    localparam logic [3:0] ODD_PAD_LINE = 4'b1010;
    // A hold-off this long fills every buffer in the block.
    localparam int HOLD_CYCLES = 400;
    // Cycles allowed for the block to settle after the last result item.
    localparam int SETTLE_CYCLES = 8;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_EVEN_FOOTER;
    logic [7:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    nibble_stuff_manchester_frame_encoder_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Our own copy of the encoder state and of the two footer registers.
    logic [7:0] frame_sum     = '0;
    logic [3:0] leftover_line = '0;
    logic       leftover_full = 1'b0;
    logic [7:0] even_footer_r = '0;
    logic [7:0] odd_footer_r  = '0;

    // Line-coded bytes still owed by the block, oldest first.
    out_item_t  coded_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int n_errors    = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_frames    = 0;

    // Twenty line bits of one byte: high nibble first, each nibble as its
    // four bits LSB first plus a stop one, each raw bit as the bit and its
    // inverse.
    function automatic logic [19:0] byte_to_line(input logic [7:0] b);
        logic [19:0] code;
        logic [3:0]  nib;
        code = '0;
        for (int n = 1; n >= 0; n--) begin
            nib = b[n*4 +: 4];
            for (int k = 0; k < 4; k++) begin
                code = {code[17:0], nib[k], ~nib[k]};
            end
            code = {code[17:0], 2'b10};
        end
        return code;
    endfunction

    function automatic void owe_byte(input logic [7:0] b, input logic last);
        out_item_t r;
        r.coded_byte = b;
        r.frame_end  = last;
        coded_q.insert(coded_q.size(), r);
    endfunction

    // Packs one frame byte into the line stream. Twenty bits never fill a
    // whole number of bytes, so four bits are carried over on every other
    // frame byte.
    function automatic void line_code_byte(input logic [7:0] b);
        logic [19:0] code;
        logic [23:0] joined;
        code = byte_to_line(b);
        if (leftover_full) begin
            joined = {leftover_line, code};
            owe_byte(joined[23:16], 1'b0);
            owe_byte(joined[15:8], 1'b0);
            owe_byte(joined[7:0], 1'b0);
            leftover_line = '0;
            leftover_full = 1'b0;
        end else begin
            owe_byte(code[19:12], 1'b0);
            owe_byte(code[11:4], 1'b0);
            leftover_line = code[3:0];
            leftover_full = 1'b1;
        end
    endfunction

    // Expected result items of one accepted payload item.
    function automatic void predict_coded(input in_item_t it);
        logic [7:0] check;
        frame_sum = frame_sum + it.data_byte;
        line_code_byte(it.data_byte);
        if (it.last_byte) begin
            check = 8'h00 - frame_sum;
            line_code_byte(check);
            if (leftover_full) begin
                owe_byte({leftover_line, ODD_PAD_LINE}, 1'b0);
                owe_byte(odd_footer_r, 1'b1);
            end else begin
                owe_byte(even_footer_r, 1'b1);
            end
            frame_sum     = '0;
            leftover_line = '0;
            leftover_full = 1'b0;
            n_frames++;
        end
    endfunction

    // Offers one payload item, after a random gap, and returns at the edge
    // that accepts it. Valid is left high; the next call or wait_idle
    // decides what it does next, in the same time step.
    task automatic send_item(input logic [7:0] d, input logic last);
        in_item_t it;
        it.data_byte = d;
        it.last_byte = last;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_coded(it);
        n_items++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Stops offering items and waits until every owed result item is in.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (coded_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Lowers cfg_we again before returning so that back-to-back writes never
    // touch cfg_we twice in one time step.
    task automatic write_cfg(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_EVEN_FOOTER) begin
            even_footer_r = val;
        end else begin
            odd_footer_r = val;
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Footers are still at their reset value here, so the first frames show
    // that reset cleared both registers.
    task automatic test_reset_footers();
        send_item(8'h00, 1'b1);
        send_item(8'h5A, 1'b0);
        send_item(8'hC3, 1'b1);
        wait_idle();
    endtask

    // Every byte is both first and last: a frame of payload plus checksum.
    task automatic test_one_byte_frames();
        write_cfg(CFG_EVEN_FOOTER, 8'hFF);
        write_cfg(CFG_ODD_FOOTER, 8'h00);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(8'h80, 1'b1);
        send_item(8'h01, 1'b1);
        wait_idle();
    endtask

    // Frames of both parities, with sums that wrap and a zero checksum.
    task automatic test_frame_parity();
        write_cfg(CFG_EVEN_FOOTER, 8'h00);
        write_cfg(CFG_ODD_FOOTER, 8'hFF);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hAA, 1'b1);
        send_item(8'h0F, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'hFF, 1'b1);
        wait_idle();
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // block fills up and has to hold its input back.
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_cfg(CFG_EVEN_FOOTER, 8'h3C);
        write_cfg(CFG_ODD_FOOTER, 8'hC3);
        hold_req++;
        send_frame(7);
        send_frame(12);
        send_frame(1);
        send_frame(10);
        wait_idle();
    endtask

    // Random frames, mostly short with a few long ones, under one idle mix.
    task automatic test_random_frames(input int tx_pct, input int rx_pct, input int count);
        int stop_at;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_cfg(CFG_EVEN_FOOTER, 8'($urandom_range(255)));
        write_cfg(CFG_ODD_FOOTER, 8'($urandom_range(255)));
        stop_at = n_items + count;
        while (n_items < stop_at) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(24, 7);
            end else begin
                len = $urandom_range(6, 1);
            end
            send_frame(len);
        end
        wait_idle();
    endtask

    // Result side: checks every accepted result item against the oldest
    // owed byte, then decides whether to accept in the next cycle.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (coded_q.size() == 0) begin
                $error("result item with none owed: coded_byte %02h frame_end %0b",
                       m_data.coded_byte, m_data.frame_end);
                n_errors++;
            end else begin
                want = coded_q.pop_front();
                if (m_data.coded_byte !== want.coded_byte) begin
                    $error("coded_byte: expected %02h, got %02h",
                           want.coded_byte, m_data.coded_byte);
                    n_errors++;
                end
                if (m_data.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b",
                           want.frame_end, m_data.frame_end);
                    n_errors++;
                end
                n_results++;
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_footers();
        test_one_byte_frames();
        test_frame_parity();
        test_output_stall();
        test_random_frames(25, 62, 108);
        test_random_frames(62, 25, 108);
        test_random_frames(0, 0, 108);

        $display("Ran %0d frames of %0d payload items and checked %0d result items,",
                 n_frames, n_items, n_results);
        $display("with footer extremes, both parities, idle mixes and a long output stall.");
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Far beyond the slowest correct run; a hung block ends up here.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
